[hw/rtl/rmq_pkg.sv]
`default_nettype none
package rmq_pkg;
   localparam int DataWidth = 16;
   localparam int FracBits = 14;
   // component width: sums of up to three elements plus one
   localparam int CompWidth = DataWidth + 3;
   localparam int MagWidth = CompWidth - 1;
   // sum of four squares
   localparam int SqWidth = 2 * MagWidth + 2;
   localparam int LenWidth = SqWidth / 2;
   localparam int NumWidth = MagWidth + FracBits;
   localparam int QuoWidth = NumWidth;

   typedef enum logic [1:0] {
      BR_TRACE = 2'd0,
      BR_X     = 2'd1,
      BR_Y     = 2'd2,
      BR_Z     = 2'd3
   } branch_type;

   typedef logic signed [CompWidth-1:0] comp_type;

   typedef struct packed {
      comp_type [3:0] c;
      branch_type     br;
      logic           degen;
   } vec_type;
endpackage
`default_nettype wire

[hw/rtl/rmq_branch.sv]
`default_nettype none
module rmq_branch (
   input  wire logic                                   clock,
   input  wire logic                                   en,
   input  wire logic signed [rmq_pkg::DataWidth-1:0]   m [9],
   output rmq_pkg::vec_type                            vec_ff
);
   localparam rmq_pkg::comp_type One = rmq_pkg::comp_type'(1 <<< rmq_pkg::FracBits);

   rmq_pkg::vec_type vec_in;
   rmq_pkg::comp_type e [9];
   rmq_pkg::comp_type t, d;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         e[i] = rmq_pkg::comp_type'(m[i]);
      end
      t = e[0] + e[4] + e[8];
      vec_in = '0;
      d = One;
      if (t > 0) begin
         vec_in.br = rmq_pkg::BR_TRACE;
         vec_in.c[0] = e[7] - e[5];
         vec_in.c[1] = e[2] - e[6];
         vec_in.c[2] = e[3] - e[1];
         vec_in.c[3] = t + One;
      end else if (e[0] > e[4] && e[0] > e[8]) begin
         vec_in.br = rmq_pkg::BR_X;
         d = One + e[0] - e[4] - e[8];
         vec_in.c[0] = d;
         vec_in.c[1] = e[1] + e[3];
         vec_in.c[2] = e[2] + e[6];
         vec_in.c[3] = e[7] - e[5];
      end else if (e[4] > e[0] && e[4] > e[8]) begin
         vec_in.br = rmq_pkg::BR_Y;
         d = One + e[4] - e[0] - e[8];
         vec_in.c[0] = e[1] + e[3];
         vec_in.c[1] = d;
         vec_in.c[2] = e[5] + e[7];
         vec_in.c[3] = e[2] - e[6];
      end else begin
         vec_in.br = rmq_pkg::BR_Z;
         d = One + e[8] - e[0] - e[4];
         vec_in.c[0] = e[2] + e[6];
         vec_in.c[1] = e[5] + e[7];
         vec_in.c[2] = d;
         vec_in.c[3] = e[3] - e[1];
      end
      vec_in.degen = (d <= 0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end
endmodule
`default_nettype wire

[hw/rtl/rmq_sqrt_stage.sv]
`default_nettype none
// one restoring square root step: two radicand bits per stage
module rmq_sqrt_stage (
   input  wire logic [rmq_pkg::SqWidth-1:0]  rem,
   input  wire logic [rmq_pkg::LenWidth-1:0] root,
   input  wire logic [1:0]                   pair,
   output logic      [rmq_pkg::SqWidth-1:0]  rem_next,
   output logic      [rmq_pkg::LenWidth-1:0] root_next
);
   logic [rmq_pkg::SqWidth+1:0] shifted, trial;

   always_comb begin
      shifted = {rem, pair};
      trial = {{(rmq_pkg::SqWidth-rmq_pkg::LenWidth){1'b0}}, root, 2'b01};
      if (shifted >= trial) begin
         rem_next = rmq_pkg::SqWidth'(shifted - trial);
         root_next = {root[rmq_pkg::LenWidth-2:0], 1'b1};
      end else begin
         rem_next = rmq_pkg::SqWidth'(shifted);
         root_next = {root[rmq_pkg::LenWidth-2:0], 1'b0};
      end
   end
endmodule
`default_nettype wire

[hw/rtl/rmq_div_stage.sv]
`default_nettype none
// one restoring division step for the four components in parallel
module rmq_div_stage (
   input  wire logic [rmq_pkg::LenWidth:0]   rem   [4],
   input  wire logic [rmq_pkg::NumWidth-1:0] num   [4],
   input  wire logic [rmq_pkg::LenWidth-1:0] len,
   output logic      [rmq_pkg::LenWidth:0]   rem_next [4],
   output logic      [rmq_pkg::NumWidth-1:0] num_next [4]
);
   logic [rmq_pkg::LenWidth+1:0] sh;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sh = {rem[i], num[i][rmq_pkg::NumWidth-1]};
         if (sh >= {2'b00, len}) begin
            rem_next[i] = (rmq_pkg::LenWidth+1)'(sh - {2'b00, len});
            num_next[i] = {num[i][rmq_pkg::NumWidth-2:0], 1'b1};
         end else begin
            rem_next[i] = (rmq_pkg::LenWidth+1)'(sh);
            num_next[i] = {num[i][rmq_pkg::NumWidth-2:0], 1'b0};
         end
      end
   end
endmodule
`default_nettype wire

[hw/rtl/rotation_matrix_to_quaternion_unit.sv]
`default_nettype none
// rotation matrix to unit quaternion, Shepperd's branch selection
// req channel: one 3x3 matrix per item, nine signed q1.14 elements in tdata
// rsp channel: qx, qy, qz, qw (signed q1.14, saturated), branch and degenerate flag
// the datapath is a stall-as-a-whole pipeline: every stage advances when the
// output register is empty or being taken, so one item per cycle is sustained
// stages: 1 branch stage + 1 square stage + 19 sqrt stages (one root bit each)
// + 32 divide stages (one quotient bit each) + 1 output stage
// the depth follows from the bit-serial square root and divider chains
// reset clears all valid bits; payload registers are left as they are
// when rsp_tready is low and the output register is full, the whole pipeline
// holds and req_tready drops; nothing is lost or repeated
module rotation_matrix_to_quaternion_unit (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0, 16 bits each
   input  wire logic [143:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // qx, qy, qz, qw, branch_taken, degenerate from bit 0, zero padded
   output logic [71:0]        rsp_tdata
);
   localparam int DW = rmq_pkg::DataWidth;
   localparam int MW = rmq_pkg::MagWidth;
   localparam int LW = rmq_pkg::LenWidth;
   localparam int NW = rmq_pkg::NumWidth;
   localparam int SW = rmq_pkg::SqWidth;
   localparam int SqSt = LW;
   localparam int DvSt = NW;
   localparam int Depth = 2 + SqSt + DvSt;

   // global advance: output register empty or drained
   logic adv;
   logic [Depth-1:0] valid_ff;
   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rsp_tvalid <= 1'b0;
      end else if (adv) begin
         valid_ff <= {valid_ff[Depth-2:0], req_tvalid};
         rsp_tvalid <= valid_ff[Depth-1];
      end
   end

   // stage 0: branch selection
   logic signed [DW-1:0] m [9];
   rmq_pkg::vec_type vec_ff;
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         m[i] = req_tdata[i*DW +: DW];
      end
   end
   rmq_branch u_branch (.clock(clock), .en(adv), .m(m), .vec_ff(vec_ff));

   // side data carried alongside: signs, magnitudes, branch, degenerate
   typedef struct packed {
      logic [3:0]          neg;
      logic [3:0][MW-1:0]  mag;
      rmq_pkg::branch_type br;
      logic                degen;
   } side_type;

   // stage 1: sum of squares
   side_type side1_ff;
   logic [SW-1:0] sq_ff;
   side_type side1_in;
   logic [SW-1:0] sq_in;
   always_comb begin
      side1_in.br = vec_ff.br;
      side1_in.degen = vec_ff.degen;
      sq_in = '0;
      for (int i = 0; i < 4; i++) begin
         side1_in.neg[i] = vec_ff.c[i][rmq_pkg::CompWidth-1];
         side1_in.mag[i] = MW'(vec_ff.c[i][rmq_pkg::CompWidth-1] ?
                               -vec_ff.c[i] : vec_ff.c[i]);
         sq_in = sq_in + SW'(side1_in.mag[i] * side1_in.mag[i]);
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         side1_ff <= side1_in;
         sq_ff <= sq_in;
      end
   end

   // square root chain
   side_type side_s_ff [SqSt];
   logic [SW-1:0] rad_ff [SqSt];
   logic [SW-1:0] rem_ff [SqSt];
   logic [LW-1:0] root_ff [SqSt];
   for (genvar k = 0; k < SqSt; k++) begin : g_sqrt
      side_type side_i;
      logic [SW-1:0] rad_i;
      logic [SW-1:0] rem_i;
      logic [LW-1:0] root_i;
      logic [SW-1:0] rem_n;
      logic [LW-1:0] root_n;
      if (k == 0) begin : g_first
         assign side_i = side1_ff;
         assign rad_i = sq_ff;
         assign rem_i = '0;
         assign root_i = '0;
      end else begin : g_next
         assign side_i = side_s_ff[k-1];
         assign rad_i = rad_ff[k-1];
         assign rem_i = rem_ff[k-1];
         assign root_i = root_ff[k-1];
      end
      rmq_sqrt_stage u_sq (
         .rem(rem_i), .root(root_i),
         .pair(rad_i[SW-1 -: 2]),
         .rem_next(rem_n), .root_next(root_n));
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= rem_n;
            root_ff[k] <= root_n;
            rad_ff[k] <= {rad_i[SW-3:0], 2'b00};
            side_s_ff[k] <= side_i;
         end
      end
   end

   // divider chain; numerator n = mag << frac plus len/2 rounding
   side_type side_d_ff [DvSt];
   logic [LW-1:0] len_ff [DvSt];
   logic [LW:0] drem_ff [DvSt] [4];
   logic [NW-1:0] num_ff [DvSt] [4];
   for (genvar k = 0; k < DvSt; k++) begin : g_div
      side_type side_i;
      logic [LW-1:0] len_i;
      logic [LW:0] rem_i [4];
      logic [NW-1:0] num_i [4];
      logic [LW:0] rem_n [4];
      logic [NW-1:0] num_n [4];
      if (k == 0) begin : g_first
         always_comb begin
            side_i = side_s_ff[SqSt-1];
            len_i = root_ff[SqSt-1];
            for (int i = 0; i < 4; i++) begin
               rem_i[i] = '0;
               num_i[i] = NW'({side_s_ff[SqSt-1].mag[i], {rmq_pkg::FracBits{1'b0}}})
                          + NW'(root_ff[SqSt-1] >> 1);
            end
         end
      end else begin : g_next
         always_comb begin
            side_i = side_d_ff[k-1];
            len_i = len_ff[k-1];
            rem_i = drem_ff[k-1];
            num_i = num_ff[k-1];
         end
      end
      rmq_div_stage u_dv (
         .rem(rem_i), .num(num_i), .len(len_i),
         .rem_next(rem_n), .num_next(num_n));
      always_ff @(posedge clock) begin
         if (adv) begin
            drem_ff[k] <= rem_n;
            num_ff[k] <= num_n;
            len_ff[k] <= len_i;
            side_d_ff[k] <= side_i;
         end
      end
   end

   // output stage: sign, saturation, degenerate zeroing
   logic [71:0] out_in;
   logic        dg;
   logic [NW:0] q;
   always_comb begin
      out_in = '0;
      dg = side_d_ff[DvSt-1].degen || (len_ff[DvSt-1] == '0);
      q = '0;
      for (int i = 0; i < 4; i++) begin
         q = {1'b0, num_ff[DvSt-1][i]};
         if (dg) begin
            out_in[i*DW +: DW] = '0;
         end else if (side_d_ff[DvSt-1].neg[i]) begin
            out_in[i*DW +: DW] = (q > (NW+1)'(1 << (DW-1))) ?
               DW'(1 << (DW-1)) : DW'(-q);
         end else begin
            out_in[i*DW +: DW] = (q > (NW+1)'((1 << (DW-1)) - 1)) ?
               DW'((1 << (DW-1)) - 1) : DW'(q);
         end
      end
      out_in[4*DW +: 2] = side_d_ff[DvSt-1].br;
      out_in[4*DW+2] = dg;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata <= out_in;
      end
   end

   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_rdy : assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready mismatch");
   a_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4*DW+2] |-> rsp_tdata[4*DW-1:0] == '0)
      else $error("degenerate result not zero");
endmodule
`default_nettype wire
